/* design/avr_pkg.sv */
`default_nettype none
package avr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_W        = 15;
  localparam int Q_W          = 16;                // Q1.15 component
  localparam int CS_W         = 34;                // CORDIC x/y, Q2.30 with headroom
  localparam int Z_W          = 26;                // residual angle, 1/65536 degree
  localparam int M_W          = 34;                // matrix entry, Q2.30
  localparam int P_W          = M_W + Q_W;         // entry times component
  localparam int ACC_W        = P_W + 2;           // sum of three products

  localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
  localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);
  localparam logic signed [CS_W-1:0] ONE_Q30     = CS_W'(64'sd1 <<< 30);

  typedef struct packed {
    logic signed [Q_W-1:0] z;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] x;
  } vec3_t;

  typedef struct packed {
    vec3_t axis;
    vec3_t vec;
  } side_t;

  typedef struct packed {
    logic signed [M_W-1:0] c2;
    logic signed [M_W-1:0] c1;
    logic signed [M_W-1:0] c0;
  } mrow_t;

  // lane register enables: [0] product stage, [1] sum stage
  typedef struct packed {
    logic sum_en;
    logic prod_en;
  } lane_en_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [Z_W-1:0] atan_deg16(input int i);
    logic signed [Z_W-1:0] r;
    r = '0;
    case (i)
      0:  r = Z_W'(2949120);
      1:  r = Z_W'(1740967);
      2:  r = Z_W'(919879);
      3:  r = Z_W'(466945);
      4:  r = Z_W'(234379);
      5:  r = Z_W'(117304);
      6:  r = Z_W'(58666);
      7:  r = Z_W'(29335);
      8:  r = Z_W'(14668);
      9:  r = Z_W'(7334);
      10: r = Z_W'(3667);
      11: r = Z_W'(1833);
      12: r = Z_W'(917);
      13: r = Z_W'(458);
      14: r = Z_W'(229);
      15: r = Z_W'(115);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/avr_cordic.sv */
`default_nettype none
module avr_cordic (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [avr_pkg::ANG_W-1:0]    in_angle,
  input  wire avr_pkg::side_t                      in_side,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [avr_pkg::CS_W-1:0]          out_cos,
  output logic signed [avr_pkg::CS_W-1:0]          out_sin,
  output avr_pkg::side_t                           out_side
);

  localparam int S = avr_pkg::CORDIC_STEPS;

  logic [S:0]                          v;
  logic [S+1:0]                        en;
  logic signed [avr_pkg::CS_W-1:0]     x [0:S];
  logic signed [avr_pkg::CS_W-1:0]     y [0:S];
  logic signed [avr_pkg::Z_W-1:0]      z [0:S];
  logic [S:0]                          neg;
  avr_pkg::side_t                      side [0:S];

  logic signed [16:0]                  a0, a1, a2;
  logic                                neg0;

  always_comb begin
    en[S+1] = out_ready;
    for (int k = S; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  // fold into [-180,180], then into [-90,90] with sign flip
  always_comb begin
    a0 = 17'(in_angle);
    a1 = a0;
    if (a0 > avr_pkg::HALF_TURN) begin
      a1 = a0 - avr_pkg::FULL_TURN;
    end else if (a0 < -avr_pkg::HALF_TURN) begin
      a1 = a0 + avr_pkg::FULL_TURN;
    end
    a2   = a1;
    neg0 = 1'b0;
    if (a1 > avr_pkg::QUARTER_TURN) begin
      a2   = a1 - avr_pkg::HALF_TURN;
      neg0 = 1'b1;
    end else if (a1 < -avr_pkg::QUARTER_TURN) begin
      a2   = a1 + avr_pkg::HALF_TURN;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x[0]    <= avr_pkg::CORDIC_GAIN;
      y[0]    <= '0;
      z[0]    <= avr_pkg::Z_W'(a2) <<< 10;
      neg[0]  <= neg0;
      side[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= S; k++) begin : g_step
    logic signed [avr_pkg::CS_W-1:0] xs, ys;
    assign xs = x[k-1] >>> (k-1);
    assign ys = y[k-1] >>> (k-1);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (z[k-1] >= 0) begin
          x[k] <= x[k-1] - ys;
          y[k] <= y[k-1] + xs;
          z[k] <= z[k-1] - avr_pkg::atan_deg16(k-1);
        end else begin
          x[k] <= x[k-1] + ys;
          y[k] <= y[k-1] - xs;
          z[k] <= z[k-1] + avr_pkg::atan_deg16(k-1);
        end
        neg[k]  <= neg[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = v[S];
  assign out_cos   = neg[S] ? -x[S] : x[S];
  assign out_sin   = neg[S] ? -y[S] : y[S];
  assign out_side  = side[S];

endmodule
`default_nettype wire

/* design/avr_matrix.sv */
`default_nettype none
module avr_matrix (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [avr_pkg::CS_W-1:0] in_cos,
  input  wire logic signed [avr_pkg::CS_W-1:0] in_sin,
  input  wire avr_pkg::side_t                  in_side,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output avr_pkg::mrow_t                       out_row [0:2],
  output avr_pkg::vec3_t                       out_vec
);

  localparam int MW = avr_pkg::M_W;
  localparam int W2 = 2 * avr_pkg::Q_W;           // 16x16 product
  localparam int WS = avr_pkg::Q_W + avr_pkg::CS_W; // axis times sine
  localparam int WL = 68;                           // Q2.30 by Q2.30 product

  function automatic logic signed [MW-1:0] rnd30(input logic signed [WL-1:0] p);
    logic signed [WL-1:0] t;
    t = (p + (WL'(1) <<< 29)) >>> 30;
    return t[MW-1:0];
  endfunction

  function automatic logic signed [MW-1:0] rnd15(input logic signed [WS-1:0] p);
    logic signed [WS-1:0] t;
    t = (p + (WS'(1) <<< 14)) >>> 15;
    return t[MW-1:0];
  endfunction

  logic [2:0] v;
  logic [3:0] en;

  always_comb begin
    en[3] = out_ready;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  // stage A: axis products, 1 - cos
  logic signed [avr_pkg::CS_W-1:0] a_c, a_cc;
  logic signed [W2-1:0]            a_xx, a_yy, a_zz, a_xy, a_xz, a_yz;
  logic signed [WS-1:0]            a_sx, a_sy, a_sz;
  avr_pkg::vec3_t                  a_vec;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_c   <= in_cos;
      a_cc  <= avr_pkg::ONE_Q30 - in_cos;
      a_xx  <= W2'(in_side.axis.x) * W2'(in_side.axis.x);
      a_yy  <= W2'(in_side.axis.y) * W2'(in_side.axis.y);
      a_zz  <= W2'(in_side.axis.z) * W2'(in_side.axis.z);
      a_xy  <= W2'(in_side.axis.x) * W2'(in_side.axis.y);
      a_xz  <= W2'(in_side.axis.x) * W2'(in_side.axis.z);
      a_yz  <= W2'(in_side.axis.y) * W2'(in_side.axis.z);
      a_sx  <= WS'(in_side.axis.x) * WS'(in_sin);
      a_sy  <= WS'(in_side.axis.y) * WS'(in_sin);
      a_sz  <= WS'(in_side.axis.z) * WS'(in_sin);
      a_vec <= in_side.vec;
    end
  end

  // stage B: rounded products with cos, 1 - cos and sine
  logic signed [MW-1:0] b_xx, b_yy, b_zz, b_dxx, b_dyy, b_dzz;
  logic signed [MW-1:0] b_xy, b_xz, b_yz, b_sx, b_sy, b_sz;
  avr_pkg::vec3_t       b_vec;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_xx  <= MW'(a_xx);
      b_yy  <= MW'(a_yy);
      b_zz  <= MW'(a_zz);
      b_dxx <= rnd30(WL'(avr_pkg::ONE_Q30 - MW'(a_xx)) * WL'(a_c));
      b_dyy <= rnd30(WL'(avr_pkg::ONE_Q30 - MW'(a_yy)) * WL'(a_c));
      b_dzz <= rnd30(WL'(avr_pkg::ONE_Q30 - MW'(a_zz)) * WL'(a_c));
      b_xy  <= rnd30(WL'(a_cc) * WL'(a_xy));
      b_xz  <= rnd30(WL'(a_cc) * WL'(a_xz));
      b_yz  <= rnd30(WL'(a_cc) * WL'(a_yz));
      b_sx  <= rnd15(a_sx);
      b_sy  <= rnd15(a_sy);
      b_sz  <= rnd15(a_sz);
      b_vec <= a_vec;
    end
  end

  // stage C: matrix entries
  avr_pkg::mrow_t c_row [0:2];
  avr_pkg::vec3_t c_vec;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_row[0].c0 <= b_xx + b_dxx;
      c_row[0].c1 <= b_xy - b_sz;
      c_row[0].c2 <= b_xz + b_sy;
      c_row[1].c0 <= b_xy + b_sz;
      c_row[1].c1 <= b_yy + b_dyy;
      c_row[1].c2 <= b_yz - b_sx;
      c_row[2].c0 <= b_xz - b_sy;
      c_row[2].c1 <= b_yz + b_sx;
      c_row[2].c2 <= b_zz + b_dzz;
      c_vec       <= b_vec;
    end
  end

  assign out_valid = v[2];
  assign out_row   = c_row;
  assign out_vec   = c_vec;

endmodule
`default_nettype wire

/* design/avr_row_lane.sv */
`default_nettype none
module avr_row_lane (
  input  wire logic                          clk,
  input  wire avr_pkg::lane_en_t             en,
  input  wire avr_pkg::mrow_t                row,
  input  wire avr_pkg::vec3_t                vec,
  output logic signed [avr_pkg::Q_W-1:0]     res
);

  localparam int PW = avr_pkg::P_W;
  localparam int AW = avr_pkg::ACC_W;

  logic signed [PW-1:0] p0, p1, p2;
  logic signed [AW-1:0] acc, rnd;

  always_ff @(posedge clk) begin
    if (en.prod_en) begin
      p0 <= PW'(row.c0) * PW'(vec.x);
      p1 <= PW'(row.c1) * PW'(vec.y);
      p2 <= PW'(row.c2) * PW'(vec.z);
    end
  end

  always_comb begin
    acc = AW'(p0) + AW'(p1) + AW'(p2);
    rnd = (acc + (AW'(1) <<< 29)) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (en.sum_en) begin
      if (rnd > AW'(32767)) begin
        res <= 16'sh7fff;
      end else if (rnd < -AW'(32768)) begin
        res <= -16'sh8000;
      end else begin
        res <= rnd[avr_pkg::Q_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

/* design/axis_angle_vector_rotation_core.sv */
`default_nettype none
// Axis-angle rotation of a Q1.15 direction vector. Each request carries a
// rotation axis (unit length expected), an angle in 1/64 degree and the
// vector; the result is the vector rotated by the Rodrigues matrix, each
// component rounded and saturated to Q1.15. Angles outside +-180 degrees
// wrap. One request is taken every clock cycle while the output is not
// stalled. The angle fold and the 16-step pipelined CORDIC come first,
// then the matrix build, then the three row lanes (products, then sum
// with rounding and saturation) and last the output register that
// merges the lanes. Every stage holds its request while stalled and fills
// bubbles, so a waiting result never blocks new requests until the pipe is
// full.
module axis_angle_vector_rotation_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // axis_x, axis_y, axis_z, angle[14:0], vec_x, vec_y, vec_z, one zero pad bit
  input  wire logic [111:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_x, out_y, out_z
  output logic [47:0]       m_tdata
);

  avr_pkg::side_t  in_side;
  logic signed [avr_pkg::ANG_W-1:0] in_angle;

  assign in_side.axis.x = s_tdata[15:0];
  assign in_side.axis.y = s_tdata[31:16];
  assign in_side.axis.z = s_tdata[47:32];
  assign in_angle       = s_tdata[62:48];
  assign in_side.vec.x  = s_tdata[78:63];
  assign in_side.vec.y  = s_tdata[94:79];
  assign in_side.vec.z  = s_tdata[110:95];

  logic                              cs_valid, cs_ready;
  logic signed [avr_pkg::CS_W-1:0]   cs_cos, cs_sin;
  avr_pkg::side_t                    cs_side;

  avr_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_angle  (in_angle),
    .in_side   (in_side),
    .out_valid (cs_valid),
    .out_ready (cs_ready),
    .out_cos   (cs_cos),
    .out_sin   (cs_sin),
    .out_side  (cs_side)
  );

  logic            mx_valid;
  avr_pkg::mrow_t  mx_row [0:2];
  avr_pkg::vec3_t  mx_vec;

  // lane and output stage control
  logic             vd, ve, vo;
  logic             d_en, e_en, o_en;
  avr_pkg::lane_en_t lane_en;

  assign o_en = !vo || m_tready;
  assign e_en = !ve || o_en;
  assign d_en = !vd || e_en;
  assign lane_en.prod_en = d_en;
  assign lane_en.sum_en  = e_en;

  avr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cs_valid),
    .in_ready  (cs_ready),
    .in_cos    (cs_cos),
    .in_sin    (cs_sin),
    .in_side   (cs_side),
    .out_valid (mx_valid),
    .out_ready (d_en),
    .out_row   (mx_row),
    .out_vec   (mx_vec)
  );

  // one lane per output component
  logic signed [avr_pkg::Q_W-1:0] lane_res [0:2];

  for (genvar r = 0; r < 3; r++) begin : g_lane
    avr_row_lane u_lane (
      .clk (clk),
      .en  (lane_en),
      .row (mx_row[r]),
      .vec (mx_vec),
      .res (lane_res[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (d_en) vd <= mx_valid;
      if (e_en) ve <= vd;
      if (o_en) vo <= ve;
    end
  end

  // merge the lanes into the output word
  always_ff @(posedge clk) begin
    if (o_en) begin
      m_tdata <= {lane_res[2], lane_res[1], lane_res[0]};
    end
  end

  assign m_tvalid = vo;

endmodule
`default_nettype wire
